FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the sorted key record table.
// No dependencies; files that assert include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, ignored while in reset.
`define SKRT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("skrt check failed");

// Implication check: when the condition holds, the consequence holds too.
`define SKRT_ASSERT_IMP(lbl, cond, conseq) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error("skrt implication failed");

`endif

FILE: hw/rtl/skrt_pkg.sv
// Package of the sorted key record table: record type, codes and sizes.
// Used by skrt_mem, skrt_ctrl and sorted_key_record_table_core.
`timescale 1ns / 1ps

package skrt_pkg;

   localparam int DEFAULT_DEPTH = 16;

   typedef enum logic [1:0] {
      OP_INSERT    = 2'd0,
      OP_DELETE    = 2'd1,
      OP_FIND_KEY  = 2'd2,
      OP_FIND_TOTAL = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_DELETED   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FOUND     = 3'd4,
      ST_FULL      = 3'd5
   } status_type;

   typedef struct packed {
      logic [11:0] total;
      logic [9:0]  c;
      logic [9:0]  b;
      logic [9:0]  a;
      logic [31:0] key;
   } rec_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PUT,
      S_DEL_RD,
      S_DEL_WR
   } state_type;

endpackage

FILE: hw/rtl/skrt_mem.sv
// Record memory of the sorted key record table: one write port and one
// read port with registered read data. Depends on skrt_pkg.
`timescale 1ns / 1ps

module skrt_mem
   import skrt_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  rec_type                  wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output rec_type                  rdata
);

   rec_type mem [DEPTH];
   rec_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/skrt_ctrl.sv
// Sequencer of the sorted key record table: scans, shifts and writes back
// records through the record memory and holds the result word. Depends on skrt_pkg.
`timescale 1ns / 1ps

module skrt_ctrl
   import skrt_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [79:0]              req_tdata,
   input  logic [1:0]               req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [87:0]              rsp_tdata,
   output logic [2:0]               rsp_tuser,
   output logic                     rsp_tlast,
   output logic                     mem_we,
   output logic [$clog2(DEPTH)-1:0] mem_waddr,
   output rec_type                  mem_wdata,
   output logic [$clog2(DEPTH)-1:0] mem_raddr,
   input  rec_type                  mem_rdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   state_type state_ff, state_in;
   op_type op_ff, op_in;
   rec_type new_ff, new_in;
   logic [11:0] want_ff, want_in;
   logic [CW-1:0] idx_ff, idx_in, pos_ff, pos_in, cnt_ff, cnt_in;
   logic pend_ff, pend_in;
   rec_type pend_rec_ff, pend_rec_in;
   logic [CW-1:0] pend_slot_ff, pend_slot_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [87:0] rsp_data_ff, rsp_data_in;
   logic [2:0] rsp_user_ff, rsp_user_in;
   logic rsp_last_ff, rsp_last_in;

   logic out_free, emit, e_last;
   status_type e_status;
   logic [CW-1:0] e_slot, e_entries, idx_dec;
   rec_type e_rec, zero_rec;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign idx_dec  = idx_ff - 1'b1;
   assign zero_rec = '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      op_ff        <= op_in;
      new_ff       <= new_in;
      want_ff      <= want_in;
      idx_ff       <= idx_in;
      pos_ff       <= pos_in;
      pend_rec_ff  <= pend_rec_in;
      pend_slot_ff <= pend_slot_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      new_in       = new_ff;
      want_in      = want_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      pend_rec_in  = pend_rec_ff;
      pend_slot_in = pend_slot_ff;
      req_tready   = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff[AW-1:0];
      mem_wdata    = mem_rdata;
      mem_raddr    = idx_ff[AW-1:0];
      emit         = 1'b0;
      e_status     = ST_NOT_FOUND;
      e_slot       = '0;
      e_rec        = zero_rec;
      e_last       = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in         = op_type'(req_tuser);
               new_in.key    = req_tdata[31:0];
               new_in.a      = req_tdata[41:32];
               new_in.b      = req_tdata[51:42];
               new_in.c      = req_tdata[61:52];
               new_in.total  = 12'(req_tdata[41:32]) + 12'(req_tdata[51:42])
                               + 12'(req_tdata[61:52]);
               want_in       = req_tdata[73:62];
               idx_in        = '0;
               pend_in       = 1'b0;
               state_in      = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (idx_ff == cnt_ff) begin
               if (op_ff == OP_INSERT && cnt_ff != FULL_COUNT) begin
                  pos_in   = cnt_ff;
                  state_in = S_PUT;
               end else if (out_free) begin
                  emit     = 1'b1;
                  state_in = S_IDLE;
                  if (op_ff == OP_INSERT) begin
                     e_status = ST_FULL;
                  end else if (op_ff == OP_FIND_TOTAL && pend_ff) begin
                     e_status = ST_FOUND;
                     e_slot   = pend_slot_ff;
                     e_rec    = pend_rec_ff;
                  end
               end
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (op_ff == OP_FIND_TOTAL) begin
               if (mem_rdata.total != want_ff) begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_SCAN_RD;
               end else if (!pend_ff || out_free) begin
                  emit         = pend_ff;
                  e_status     = ST_FOUND;
                  e_slot       = pend_slot_ff;
                  e_rec        = pend_rec_ff;
                  e_last       = 1'b0;
                  pend_in      = 1'b1;
                  pend_rec_in  = mem_rdata;
                  pend_slot_in = idx_ff;
                  idx_in       = idx_ff + 1'b1;
                  state_in     = S_SCAN_RD;
               end
            end else if (mem_rdata.key == new_ff.key) begin
               if (op_ff == OP_DELETE) begin
                  pend_rec_in = mem_rdata;
                  pos_in      = idx_ff;
                  idx_in      = idx_ff + 1'b1;
                  state_in    = S_DEL_RD;
               end else if (out_free) begin
                  emit     = 1'b1;
                  e_status = (op_ff == OP_INSERT) ? ST_DUPLICATE : ST_FOUND;
                  e_slot   = idx_ff;
                  e_rec    = mem_rdata;
                  state_in = S_IDLE;
               end
            end else if (mem_rdata.key > new_ff.key) begin
               if (op_ff == OP_INSERT && cnt_ff != FULL_COUNT) begin
                  pos_in   = idx_ff;
                  idx_in   = cnt_ff;
                  state_in = S_SHIFT_RD;
               end else if (out_free) begin
                  emit     = 1'b1;
                  e_status = (op_ff == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
                  state_in = S_IDLE;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            mem_raddr = idx_dec[AW-1:0];
            state_in  = (idx_ff == pos_ff) ? S_PUT : S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            mem_we   = 1'b1;
            idx_in   = idx_dec;
            state_in = S_SHIFT_RD;
         end
         S_PUT: begin
            if (out_free) begin
               mem_we    = 1'b1;
               mem_waddr = pos_ff[AW-1:0];
               mem_wdata = new_ff;
               cnt_in    = cnt_ff + 1'b1;
               emit      = 1'b1;
               e_status  = ST_INSERTED;
               e_slot    = pos_ff;
               e_rec     = new_ff;
               state_in  = S_IDLE;
            end
         end
         S_DEL_RD: begin
            if (idx_ff == cnt_ff) begin
               if (out_free) begin
                  cnt_in   = cnt_ff - 1'b1;
                  emit     = 1'b1;
                  e_status = ST_DELETED;
                  e_slot   = pos_ff;
                  e_rec    = pend_rec_ff;
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_DEL_WR;
            end
         end
         S_DEL_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_dec[AW-1:0];
            idx_in    = idx_ff + 1'b1;
            state_in  = S_DEL_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign e_entries = cnt_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = e_status;
         rsp_last_in  = e_last;
         rsp_data_in  = {1'b0, 7'(e_entries), e_rec.total, e_rec.c, e_rec.b, e_rec.a,
                         e_rec.key, 6'(e_slot)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`include "assert_macros.svh"

   `SKRT_ASSERT(a_fill_bound, cnt_ff <= FULL_COUNT)
   `SKRT_ASSERT_IMP(a_write_states, mem_we, state_ff == S_SHIFT_WR || state_ff == S_DEL_WR || state_ff == S_PUT)
   `SKRT_ASSERT_IMP(a_count_moves_on_result, cnt_ff != $past(cnt_ff), rsp_valid_ff && rsp_last_ff)

endmodule

FILE: hw/rtl/sorted_key_record_table_core.sv
// Sorted key record table: a record memory and the sequencer that runs it.
// Depends on skrt_pkg, skrt_mem and skrt_ctrl.
`timescale 1ns / 1ps

// Holds up to DEPTH records in ascending key order in one memory with a
// registered read. One word is handled at a time. Every operation first scans
// the stored keys slot by slot, reading each slot and then checking it, until
// it meets the key, a larger one or the end (find by total scans all records).
// An insert then moves each larger record up one slot and a delete moves each
// later record down, each move a read and then a write. Find by total
// delivers one word per match, or one not-found word if none match; a word
// that waits on the output stalls the scan.

module sorted_key_record_table_core
   import skrt_pkg::*;
#(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // key, score_a, score_b, score_c, wanted_total, zero pad
   input  logic [79:0] req_tdata,
   // op
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // slot, found_key, found_a, found_b, found_c, found_total, entries, zero pad
   output logic [87:0] rsp_tdata,
   // status
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);

   logic                     mem_we;
   logic [$clog2(DEPTH)-1:0] mem_waddr;
   logic [$clog2(DEPTH)-1:0] mem_raddr;
   rec_type                  mem_wdata;
   rec_type                  mem_rdata;

   skrt_mem #(.DEPTH(DEPTH)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   skrt_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

endmodule
